>>> src/bres_pkg.sv
`timescale 1ns / 1ps

package bres_pkg;

    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 24;
    localparam int DELTA_BITS = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef struct packed {
        logic   opcode;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } bres_in_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   last_pixel;
    } bres_out_t;

    // line setup or step request, as handed from front to back
    typedef struct packed {
        logic   is_load;
        logic   steep;
        coord_t major_pos;
        coord_t major_end;
        coord_t minor_pos;
        logic   minor_down;
        coord_t major_span;
        delta_t delta_err;
        color_t color;
    } bres_cmd_t;

    localparam int CMD_BITS = $bits(bres_cmd_t);
    localparam int OUT_BITS = $bits(bres_out_t);

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        abs_diff = (a > b) ? coord_t'(a - b) : coord_t'(b - a);
    endfunction

endpackage

>>> src/bres_fifo.sv
`timescale 1ns / 1ps

module bres_fifo
    import bres_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      mem [DEPTH];
    logic [ADDR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == COUNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("fifo count beyond depth");

endmodule

>>> src/bres_front.sv
`timescale 1ns / 1ps

module bres_front
    import bres_pkg::*;
(
    input  bres_in_t  item,
    output bres_cmd_t cmd
);

    coord_t dx, dy;
    logic   steep;
    coord_t a_maj, a_min, b_maj, b_min;
    logic   swap;
    coord_t first_maj, first_min, last_maj, last_min;

    always_comb
    begin
        dx    = abs_diff(item.start_x, item.end_x);
        dy    = abs_diff(item.start_y, item.end_y);
        steep = (dx < dy);

        a_maj = steep ? item.start_y : item.start_x;
        a_min = steep ? item.start_x : item.start_y;
        b_maj = steep ? item.end_y   : item.end_x;
        b_min = steep ? item.end_x   : item.end_y;

        swap      = (a_maj > b_maj);
        first_maj = swap ? b_maj : a_maj;
        first_min = swap ? b_min : a_min;
        last_maj  = swap ? a_maj : b_maj;
        last_min  = swap ? a_min : b_min;

        cmd.is_load    = (item.opcode == OP_LOAD);
        cmd.steep      = steep;
        cmd.major_pos  = first_maj;
        cmd.major_end  = last_maj;
        cmd.minor_pos  = first_min;
        cmd.minor_down = (last_min < first_min);
        cmd.major_span = coord_t'(last_maj - first_maj);
        cmd.delta_err  = {1'b0, abs_diff(first_min, last_min), 1'b0};
        cmd.color      = item.line_color;
    end

endmodule

>>> src/bres_back.sv
`timescale 1ns / 1ps

module bres_back
    import bres_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bres_cmd_t cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  logic      out_full,
    output logic      out_push,
    output bres_out_t out_word
);

    logic   active_reg, active_next;
    logic   steep_reg, steep_next;
    coord_t major_pos_reg, major_pos_next;
    coord_t major_end_reg, major_end_next;
    coord_t minor_pos_reg, minor_pos_next;
    logic   minor_down_reg, minor_down_next;
    coord_t major_span_reg, major_span_next;
    delta_t delta_err_reg, delta_err_next;
    err_t   err_acc_reg, err_acc_next;
    color_t held_color_reg, held_color_next;

    logic   is_last;
    err_t   span_ext;
    err_t   err_sum;

    assign cmd_pop  = !cmd_empty && (cmd.is_load || !out_full);
    assign out_push = cmd_pop && !cmd.is_load && active_reg;
    assign is_last  = (major_pos_reg == major_end_reg);
    assign span_ext = err_t'({{(ERR_BITS - COORD_BITS){1'b0}}, major_span_reg});
    assign err_sum  = err_acc_reg + err_t'({{(ERR_BITS - DELTA_BITS){1'b0}}, delta_err_reg});

    always_comb
    begin
        out_word.pixel_x     = steep_reg ? minor_pos_reg : major_pos_reg;
        out_word.pixel_y     = steep_reg ? major_pos_reg : minor_pos_reg;
        out_word.pixel_color = held_color_reg;
        out_word.last_pixel  = is_last;
    end

    always_comb
    begin
        active_next     = active_reg;
        steep_next      = steep_reg;
        major_pos_next  = major_pos_reg;
        major_end_next  = major_end_reg;
        minor_pos_next  = minor_pos_reg;
        minor_down_next = minor_down_reg;
        major_span_next = major_span_reg;
        delta_err_next  = delta_err_reg;
        err_acc_next    = err_acc_reg;
        held_color_next = held_color_reg;
        if (cmd_pop && cmd.is_load)
        begin
            active_next     = 1'b1;
            steep_next      = cmd.steep;
            major_pos_next  = cmd.major_pos;
            major_end_next  = cmd.major_end;
            minor_pos_next  = cmd.minor_pos;
            minor_down_next = cmd.minor_down;
            major_span_next = cmd.major_span;
            delta_err_next  = cmd.delta_err;
            err_acc_next    = '0;
            held_color_next = cmd.color;
        end
        else if (out_push)
        begin
            if (err_sum > span_ext)
            begin
                minor_pos_next = minor_down_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
                err_acc_next   = err_sum - (span_ext <<< 1);
            end
            else
            begin
                err_acc_next = err_sum;
            end
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            steep_reg      <= 1'b0;
            major_pos_reg  <= '0;
            major_end_reg  <= '0;
            minor_pos_reg  <= '0;
            minor_down_reg <= 1'b0;
            major_span_reg <= '0;
            delta_err_reg  <= '0;
            err_acc_reg    <= '0;
            held_color_reg <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            steep_reg      <= steep_next;
            major_pos_reg  <= major_pos_next;
            major_end_reg  <= major_end_next;
            minor_pos_reg  <= minor_pos_next;
            minor_down_reg <= minor_down_next;
            major_span_reg <= major_span_next;
            delta_err_reg  <= delta_err_next;
            err_acc_reg    <= err_acc_next;
            held_color_reg <= held_color_next;
        end
    end

    a_push_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> active_reg)
        else $error("pixel emitted with no active line");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && is_last) |=> !active_reg)
        else $error("line still active after last pixel");

    a_major_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (major_pos_reg <= major_end_reg))
        else $error("major position passed line end");

    a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((err_acc_reg <= span_ext) && (err_acc_reg >= -span_ext)))
        else $error("error accumulator out of bounds");

endmodule

>>> src/bresenham_line_generator_core.sv
`timescale 1ns / 1ps

// Bresenham line generator. Push a load word (opcode 0) with two endpoints and a
// color; it gives no pixel. Each step word (opcode 1) then gives one pixel, in
// order from the endpoint with the lower major coordinate, and the final pixel
// carries last_pixel. A step word with no line in progress is dropped; a load
// replaces any line in progress. Words are accepted one per clock while full is
// low, and pixels leave one per clock while popped: the setup math sits in front
// of a command queue of DEPTH words, and the back unit turns the oldest queued
// step into a pixel, pushes it into an output queue of DEPTH words and updates
// the error term; a full output queue holds the step back. A step word's pixel
// passes the command queue and then the output queue before it can be popped.

module bresenham_line_generator_core
    import bres_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bres_in_t  item,
    output logic      full,
    input  logic      pop,
    output bres_out_t pixel,
    output logic      empty
);

    bres_cmd_t             front_cmd;
    bres_cmd_t             back_cmd;
    logic [CMD_BITS-1:0]   cmd_rdata;
    logic                  cmd_empty, cmd_pop;
    logic                  out_full, out_push;
    bres_out_t             out_word;
    logic [OUT_BITS-1:0]   out_rdata;

    bres_front u_front
    (
        .item (item),
        .cmd  (front_cmd)
    );

    bres_fifo #(.WIDTH(CMD_BITS), .DEPTH(DEPTH)) u_cmd_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign back_cmd = bres_cmd_t'(cmd_rdata);

    bres_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    bres_fifo #(.WIDTH(OUT_BITS), .DEPTH(DEPTH)) u_out_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign pixel = bres_out_t'(out_rdata);

endmodule

>>> tb/line_scoreboard_pkg.sv
`timescale 1ns / 1ps

package line_scoreboard_pkg;

    import bres_pkg::*;

    class line_scoreboard;

        bit        active;
        bit        steep;
        bit        minor_down;
        coord_t    major_pos;
        coord_t    major_end;
        coord_t    minor_pos;
        coord_t    major_span;
        delta_t    delta_err;
        int        err_acc;
        color_t    held_color;
        bres_out_t pixels_due[$];
        int        mismatches;

        function new();
            active     = 1'b0;
            steep      = 1'b0;
            minor_down = 1'b0;
            major_pos  = '0;
            major_end  = '0;
            minor_pos  = '0;
            major_span = '0;
            delta_err  = '0;
            err_acc    = 0;
            held_color = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        // accepted input word: set up a line or trace one pixel of it
        function void note_word(bres_in_t w);
            coord_t    dx;
            coord_t    dy;
            coord_t    a_maj;
            coord_t    a_min;
            coord_t    b_maj;
            coord_t    b_min;
            coord_t    t;
            bres_out_t px;
            bit        last;
            if (w.opcode == OP_LOAD)
            begin
                dx = (w.start_x > w.end_x) ? w.start_x - w.end_x : w.end_x - w.start_x;
                dy = (w.start_y > w.end_y) ? w.start_y - w.end_y : w.end_y - w.start_y;
                steep = dx < dy;
                if (steep)
                begin
                    a_maj = w.start_y; a_min = w.start_x;
                    b_maj = w.end_y;   b_min = w.end_x;
                end
                else
                begin
                    a_maj = w.start_x; a_min = w.start_y;
                    b_maj = w.end_x;   b_min = w.end_y;
                end
                if (a_maj > b_maj)
                begin
                    t = a_maj; a_maj = b_maj; b_maj = t;
                    t = a_min; a_min = b_min; b_min = t;
                end
                major_pos  = a_maj;
                major_end  = b_maj;
                minor_pos  = a_min;
                minor_down = b_min < a_min;
                major_span = b_maj - a_maj;
                t          = (a_min > b_min) ? a_min - b_min : b_min - a_min;
                delta_err  = delta_t'(2 * int'(t));
                err_acc    = 0;
                held_color = w.line_color;
                active     = 1'b1;
                return;
            end
            if (!active)
                return;
            last           = (major_pos == major_end);
            px.pixel_x     = steep ? minor_pos : major_pos;
            px.pixel_y     = steep ? major_pos : minor_pos;
            px.pixel_color = held_color;
            px.last_pixel  = last;
            pixels_due.push_back(px);
            err_acc += int'(delta_err);
            if (err_acc > int'(major_span))
            begin
                minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
                err_acc -= 2 * int'(major_span);
            end
            if (last)
                active = 1'b0;
            else
                major_pos = major_pos + 1'b1;
        endfunction

        function void check_pixel(bres_out_t got);
            bres_out_t want;
            if (pixels_due.size() == 0)
            begin
                $error("pixel with none due: x %0d y %0d color %06h last %0d",
                       got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel);
                mismatches++;
                return;
            end
            want = pixels_due.pop_front();
            if (got.pixel_x !== want.pixel_x)
            begin
                $error("pixel_x: expected %0d, actual %0d", want.pixel_x, got.pixel_x);
                mismatches++;
            end
            if (got.pixel_y !== want.pixel_y)
            begin
                $error("pixel_y: expected %0d, actual %0d", want.pixel_y, got.pixel_y);
                mismatches++;
            end
            if (got.pixel_color !== want.pixel_color)
            begin
                $error("pixel_color: expected %06h, actual %06h",
                       want.pixel_color, got.pixel_color);
                mismatches++;
            end
            if (got.last_pixel !== want.last_pixel)
            begin
                $error("last_pixel: expected %0d, actual %0d",
                       want.last_pixel, got.last_pixel);
                mismatches++;
            end
        endfunction

    endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bres_pkg::*;
    import line_scoreboard_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_COORD   = (1 << COORD_BITS) - 1;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    bres_in_t  item  = '0;
    logic      full;
    logic      pop   = 1'b0;
    bres_out_t pixel;
    logic      empty;

    line_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int words_sent    = 0;

    bresenham_line_generator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .pixel (pixel),
        .empty (empty)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bres_in_t load_word(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                           color_t c);
        bres_in_t w;
        w.opcode     = OP_LOAD;
        w.start_x    = ax;
        w.start_y    = ay;
        w.end_x      = bx;
        w.end_y      = by;
        w.line_color = c;
        return w;
    endfunction

    // step words carry random junk in the unused fields
    function automatic bres_in_t step_word();
        bres_in_t w;
        w.opcode     = OP_STEP;
        w.start_x    = coord_t'($urandom);
        w.start_y    = coord_t'($urandom);
        w.end_x      = coord_t'($urandom);
        w.end_y      = coord_t'($urandom);
        w.line_color = color_t'($urandom);
        return w;
    endfunction

    function automatic coord_t pick_coord();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return coord_t'(MAX_COORD);
        return coord_t'($urandom_range(MAX_COORD));
    endfunction

    function automatic coord_t near_coord(coord_t c, int reach);
        int v;
        v = int'(c) + int'($urandom_range(2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > MAX_COORD)
            v = MAX_COORD;
        return coord_t'(v);
    endfunction

    task automatic send_word(input bres_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_word(step_word());
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // load a line, then mostly its full run of steps; sometimes cut short
    // by the next load, sometimes followed by steps on an idle block
    task automatic draw_line(input bres_in_t w);
        int dx;
        int dy;
        int span;
        int r;
        dx   = int'((w.start_x > w.end_x) ? w.start_x - w.end_x : w.end_x - w.start_x);
        dy   = int'((w.start_y > w.end_y) ? w.start_y - w.end_y : w.end_y - w.start_y);
        span = ((dx > dy) ? dx : dy) + 1;
        send_word(w);
        r = $urandom_range(99);
        if (r < 10)
            send_steps($urandom_range(span - 1));
        else if (r < 20)
            send_steps(span + $urandom_range(1, 3));
        else
            send_steps(span);
    endtask

    task automatic draw_random_line();
        coord_t ax;
        coord_t ay;
        int     reach;
        ax    = pick_coord();
        ay    = pick_coord();
        reach = ($urandom_range(19) == 0) ? 120 : 12;
        draw_line(load_word(ax, ay, near_coord(ax, reach), near_coord(ay, reach),
                            color_t'($urandom)));
    endtask

    task automatic send_noise();
        bres_in_t w;
        repeat ($urandom_range(1, 3))
        begin
            w        = step_word();
            w.opcode = logic'($urandom_range(1));
            send_word(w);
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input int target);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 8)
                send_noise();
            else
                draw_random_line();
        end
    endtask

    // receiver
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_pixel(pixel);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no word moving either way
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line, single point at the far corner
        send_word(step_word());
        send_word(load_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF));
        send_steps(1);
        send_word(step_word());
        // equal spans, treated as shallow
        send_word(load_word(10'd0, 10'd0, 10'd3, 10'd3, 24'h000000));
        send_steps(4);
        // steep, endpoints reversed, minor axis going down
        send_word(load_word(10'd0, 10'd1023, 10'd2, 10'd1019, 24'h123456));
        send_steps(5);
        // shallow reversed, replaced mid-line by a new load
        send_word(load_word(10'd1023, 10'd0, 10'd1017, 10'd2, 24'hA5C3F0));
        send_steps(3);
        send_word(load_word(10'd0, 10'd1023, 10'd1, 10'd1023, 24'h5A3C0F));
        send_steps(2);

        random_phase(35, 70, 500);
        wait_drained();
        random_phase(70, 35, 950);

        // receiver holds off while a full-width line streams in
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        draw_line(load_word(10'd0, coord_t'($urandom), 10'd1023, coord_t'($urandom),
                            color_t'($urandom)));
        random_phase(0, 0, 1950);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
src/bres_pkg.sv
src/bres_fifo.sv
src/bres_front.sv
src/bres_back.sv
src/bresenham_line_generator_core.sv
tb/line_scoreboard_pkg.sv
tb/tb_top.sv
